// ----- rtl/tcle_pkg.sv -----
package tcle_pkg;

    // default geometry and line size
    localparam int COLUMNS_DEF       = 80;
    localparam int ROWS_DEF          = 25;
    localparam int LINE_CAPACITY_DEF = 256;

    // request codes
    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_RAW   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // character codes
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // columns kept by backspace for the prompt
    localparam int PROMPT_COLS = 2;

    // attribute after reset
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // input transaction
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_t;

    // output transaction
    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_data;
        logic [7:0]  line_length;
        logic        line_done;
    } out_t;

    // what a screen sweep does
    typedef enum logic [1:0] {
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_mode_t;

    // controller to datapath
    typedef struct packed {
        logic        capture;
        logic        exec;
        logic        sweep;
        sweep_mode_t sweep_mode;
        logic        load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scroll;
        logic clear;
        logic sweep_last;
    } status_t;

endpackage

// ----- rtl/text_console_line_editor_top.sv -----
// flow: a transaction is captured into the item register, runs in the execute state, then is loaded
// into the output register in the result state, where the next transaction may be captured
// a scroll or a clear sweeps all ROWS*COLUMNS cells, one cell written per cycle
// reset: cursor, line count and attribute (7) reset at once, then a clearing pass over all
//   ROWS*COLUMNS cells blanks the screen with input stalled; config writes still taken
module text_console_line_editor_top #(
    parameter int COLUMNS       = tcle_pkg::COLUMNS_DEF,
    parameter int ROWS          = tcle_pkg::ROWS_DEF,
    parameter int LINE_CAPACITY = tcle_pkg::LINE_CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [7:0]     cfg_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  tcle_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output tcle_pkg::out_t out_data
);

    tcle_pkg::cmd_t    cmd;
    tcle_pkg::status_t status;

    // sequencing
    tcle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // cursor, line count and screen memory
    tcle_datapath #(
        .COLUMNS       (COLUMNS),
        .ROWS          (ROWS),
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    // a captured transaction is processed in the next cycle
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.exec)
        else $error("captured transaction not processed");

    // a result appears only from a load
    a_valid_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load))
        else $error("result valid without load");

    // cell edits and sweeps never share the write stage
    a_exec_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.sweep))
        else $error("edit and sweep in the same cycle");

    // a move off the bottom row starts a scroll sweep
    a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && status.scroll && !status.clear)
        |=> (cmd.sweep && cmd.sweep_mode == tcle_pkg::SWEEP_SCROLL))
        else $error("scroll not started");

endmodule

// ----- rtl/tcle_ctrl.sv -----
module tcle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tcle_pkg::status_t status,
    output tcle_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_CLEAR,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // output register can take a new result
    assign slot_free = !out_valid_reg || !out_stall;

    // commands and next state
    always_comb
    begin
        cmd            = '0;
        cmd.sweep_mode = tcle_pkg::SWEEP_INIT;
        in_stall       = 1'b1;
        state_next     = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (status.scroll)
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SCROLL:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_mode = tcle_pkg::SWEEP_SCROLL;
                if (status.sweep_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_mode = tcle_pkg::SWEEP_CLEAR;
                if (status.sweep_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // result leaves and the next transaction may enter together
                in_stall    = !slot_free;
                cmd.load    = slot_free;
                cmd.capture = slot_free && in_valid;
                if (slot_free)
                begin
                    state_next = in_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/tcle_datapath.sv -----
module tcle_datapath #(
    parameter int COLUMNS       = tcle_pkg::COLUMNS_DEF,
    parameter int ROWS          = tcle_pkg::ROWS_DEF,
    parameter int LINE_CAPACITY = tcle_pkg::LINE_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    input  tcle_pkg::in_t     in_data,
    output tcle_pkg::out_t    out_data,
    input  tcle_pkg::cmd_t    cmd,
    output tcle_pkg::status_t status
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int LIMIT = (LINE_CAPACITY - 1 > 255) ? 255 : LINE_CAPACITY - 1;

    tcle_pkg::in_t  item_reg;
    tcle_pkg::out_t out_reg;

    logic [7:0]    attr_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [7:0]    count_reg, count_next;
    logic [AW-1:0] sweep_reg, sweep_next;

    // write stage
    logic          wr_en_reg, wr_en_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic          wr_from_mem_reg, wr_from_mem_next;
    logic [15:0]   wr_data_reg, wr_data_next;

    // read port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data_reg;

    // result fields held until loaded
    logic [7:0] res_len_reg, res_len_next;
    logic       res_done_reg, res_done_next;
    logic       res_rdok_reg, res_rdok_next;

    logic [15:0] mem [CELLS];

    // decode
    logic          is_key, is_raw, is_read, is_clear;
    logic [7:0]    ch;
    logic          key_nl, key_bs, key_pr, raw_nl, raw_put, put;
    logic          at_right, at_bottom, wrap, nl_move, bs_move;
    logic [AW-1:0] cursor_addr, read_addr, sweep_src;
    logic          read_ok, copy, sweep_last;
    logic [15:0]   blank_cell;

    assign ch       = item_reg.char_code;
    assign is_key   = item_reg.req_type == tcle_pkg::REQ_KEY;
    assign is_raw   = item_reg.req_type == tcle_pkg::REQ_RAW;
    assign is_read  = item_reg.req_type == tcle_pkg::REQ_READ;
    assign is_clear = item_reg.req_type == tcle_pkg::REQ_CLEAR;

    // line editor rules
    assign key_nl  = is_key && (ch == tcle_pkg::CH_NL);
    assign key_bs  = is_key && (ch == tcle_pkg::CH_BS) && (count_reg != 8'd0);
    assign key_pr  = is_key && (ch inside {[tcle_pkg::CH_BLANK:tcle_pkg::CH_TILDE]})
                     && (count_reg < 8'(LIMIT));
    assign raw_nl  = is_raw && (ch == tcle_pkg::CH_NL);
    assign raw_put = is_raw && (ch != tcle_pkg::CH_NL);
    assign put     = key_pr || raw_put;

    // cursor motion
    assign at_right  = col_reg == CW'(COLUMNS - 1);
    assign at_bottom = row_reg == RW'(ROWS - 1);
    assign wrap      = put && at_right;
    assign nl_move   = key_nl || raw_nl || wrap;
    assign bs_move   = key_bs && (col_reg > CW'(tcle_pkg::PROMPT_COLS));

    // addresses
    assign cursor_addr = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign read_addr   = AW'(item_reg.read_row) * AW'(COLUMNS) + AW'(item_reg.read_col);
    assign read_ok     = (32'(item_reg.read_row) < 32'(ROWS))
                         && (32'(item_reg.read_col) < 32'(COLUMNS));

    // sweep over the whole screen
    assign sweep_src  = sweep_reg + AW'(COLUMNS);
    assign sweep_last = sweep_reg == AW'(CELLS - 1);
    assign copy       = (cmd.sweep_mode == tcle_pkg::SWEEP_SCROLL)
                        && (sweep_reg < AW'(CELLS - COLUMNS));
    assign blank_cell = {(cmd.sweep_mode == tcle_pkg::SWEEP_INIT) ? tcle_pkg::ATTR_RESET
                                                                   : attr_reg,
                         tcle_pkg::CH_BLANK};

    // read port select
    assign rd_en   = (cmd.sweep && copy) || (cmd.exec && is_read && read_ok);
    assign rd_addr = cmd.sweep ? sweep_src : read_addr;

    // status
    assign status.scroll     = nl_move && at_bottom;
    assign status.clear      = is_clear;
    assign status.sweep_last = sweep_last;

    // next values
    always_comb
    begin
        row_next         = row_reg;
        col_next         = col_reg;
        count_next       = count_reg;
        sweep_next       = sweep_reg;
        wr_en_next       = 1'b0;
        wr_addr_next     = cursor_addr;
        wr_from_mem_next = 1'b0;
        wr_data_next     = {attr_reg, ch};
        res_len_next     = res_len_reg;
        res_done_next    = res_done_reg;
        res_rdok_next    = res_rdok_reg;
        if (cmd.sweep)
        begin
            sweep_next       = sweep_last ? '0 : sweep_reg + AW'(1);
            wr_en_next       = 1'b1;
            wr_addr_next     = sweep_reg;
            wr_from_mem_next = copy;
            wr_data_next     = blank_cell;
        end
        else if (cmd.exec)
        begin
            res_done_next = key_nl;
            res_rdok_next = is_read && read_ok;
            // character write
            if (put)
            begin
                wr_en_next = 1'b1;
                col_next   = col_reg + CW'(1);
            end
            // backspace blanks the cell left of the cursor
            if (bs_move)
            begin
                wr_en_next   = 1'b1;
                wr_addr_next = cursor_addr - AW'(1);
                wr_data_next = {attr_reg, tcle_pkg::CH_BLANK};
                col_next     = col_reg - CW'(1);
            end
            // newline or wrap
            if (nl_move)
            begin
                col_next = '0;
                if (!at_bottom)
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            // line counter
            if (key_bs)
            begin
                count_next = count_reg - 8'd1;
            end
            else if (key_pr)
            begin
                count_next = count_reg + 8'd1;
            end
            else if (key_nl)
            begin
                count_next = 8'd0;
            end
            if (is_clear)
            begin
                row_next = '0;
                col_next = '0;
            end
            res_len_next = key_nl ? count_reg : count_next;
        end
    end

    // control and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= tcle_pkg::ATTR_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            count_reg <= 8'd0;
            sweep_reg <= '0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                attr_reg <= cfg_data;
            end
            row_reg   <= row_next;
            col_reg   <= col_next;
            count_reg <= count_next;
            sweep_reg <= sweep_next;
            wr_en_reg <= wr_en_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        wr_addr_reg     <= wr_addr_next;
        wr_from_mem_reg <= wr_from_mem_next;
        wr_data_reg     <= wr_data_next;
        res_len_reg     <= res_len_next;
        res_done_reg    <= res_done_next;
        res_rdok_reg    <= res_rdok_next;
        if (cmd.load)
        begin
            out_reg.cursor_row  <= 5'(row_reg);
            out_reg.cursor_col  <= 7'(col_reg);
            out_reg.cell_data   <= res_rdok_reg ? rd_data_reg : 16'd0;
            out_reg.line_length <= res_len_reg;
            out_reg.line_done   <= res_done_reg;
        end
    end

    // screen memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_from_mem_reg ? rd_data_reg : wr_data_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_data = out_reg;

endmodule
